>>> rtl/core/frequency_ordered_search_list_top_macros.svh
`ifndef FREQUENCY_ORDERED_SEARCH_LIST_TOP_MACROS_SVH
`define FREQUENCY_ORDERED_SEARCH_LIST_TOP_MACROS_SVH

// Overlapping implication, sampled on clk, off while rst_n is low.
`define FOSL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FOSL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fosl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fosl_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = 16;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int USED_W = $clog2(DEPTH + 1);
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;
    localparam int ACNT_W = 16;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/fosl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fosl_in_if import fosl_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface fosl_out_if import fosl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [ACNT_W-1:0] access_count;

    modport source (output valid, output status, output position, output access_count,
                    input ready);
    modport sink   (input valid, input status, input position, input access_count,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/fosl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fosl_ctrl import fosl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   in_xfer;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_UPDATE) && out_free);
    assign in_xfer  = in_valid && in_ready;

    assign cmd.load   = in_xfer;
    assign cmd.search = (state_reg == S_SEARCH);
    assign cmd.commit = (state_reg == S_UPDATE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // hold until the result register can take the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = in_xfer ? S_SEARCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/fosl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fosl_dp import fosl_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_cmd_t                 cmd,
    input  wire logic                    opcode,
    input  wire logic signed [VAL_W-1:0] value,
    output logic [STAT_W-1:0]            status,
    output logic [POS_W-1:0]             position,
    output logic [ACNT_W-1:0]            access_count
);

    logic [VAL_W-1:0]  val_reg [DEPTH];
    logic [CNT_W-1:0]  cnt_reg [DEPTH];
    logic [VAL_W-1:0]  val_prev [DEPTH];
    logic [CNT_W-1:0]  cnt_prev [DEPTH];
    logic [USED_W-1:0] used_reg;
    logic              op_reg;
    logic [VAL_W-1:0]  key_reg;

    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]  new_cnt_reg, new_cnt_next;

    logic [IDX_W-1:0]  dest_idx;
    logic [IDX_W-1:0]  tail_idx;
    logic              full;

    logic [STAT_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ACNT_W-1:0] acnt_reg, acnt_next;

    assign full     = (used_reg == USED_W'(DEPTH));
    assign tail_idx = used_reg[IDX_W-1:0];

    // neighbor taps for the one-step shift toward the tail
    assign val_prev[0] = val_reg[0];
    assign cnt_prev[0] = cnt_reg[0];
    for (genvar g = 1; g < DEPTH; g++)
    begin : g_prev
        assign val_prev[g] = val_reg[g-1];
        assign cnt_prev[g] = cnt_reg[g-1];
    end

    // parallel compare, first match from the head wins
    always_comb
    begin
        hit_next     = 1'b0;
        hit_idx_next = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if ((USED_W'(k) < used_reg) && (val_reg[k] == key_reg))
            begin
                hit_next     = 1'b1;
                hit_idx_next = IDX_W'(k);
            end
        end
        new_cnt_next = (cnt_reg[hit_idx_next] == '1) ? cnt_reg[hit_idx_next]
                                                      : cnt_reg[hit_idx_next] + 1'b1;
    end

    // destination: one past the last earlier entry whose count is greater
    always_comb
    begin
        dest_idx = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if ((IDX_W'(k) < hit_idx_reg) && (cnt_reg[k] > new_cnt_reg))
            begin
                dest_idx = IDX_W'(k + 1);
            end
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        pos_next    = '0;
        acnt_next   = '0;
        if (op_reg == OP_APPEND)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                pos_next = POS_W'(tail_idx);
            end
        end
        else if (hit_reg)
        begin
            pos_next  = POS_W'(dest_idx);
            acnt_next = ACNT_W'(new_cnt_reg);
        end
        else
        begin
            status_next = ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.commit && (op_reg == OP_APPEND) && !full)
        begin
            used_reg <= used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= value;
        end
        if (cmd.search)
        begin
            hit_reg     <= hit_next;
            hit_idx_reg <= hit_idx_next;
            new_cnt_reg <= new_cnt_next;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            acnt_reg   <= acnt_next;
            if (op_reg == OP_APPEND)
            begin
                if (!full)
                begin
                    val_reg[tail_idx] <= key_reg;
                    cnt_reg[tail_idx] <= '0;
                end
            end
            else if (hit_reg)
            begin
                for (int k = 0; k < DEPTH; k++)
                begin
                    if (IDX_W'(k) == dest_idx)
                    begin
                        val_reg[k] <= key_reg;
                        cnt_reg[k] <= new_cnt_reg;
                    end
                    else if ((IDX_W'(k) > dest_idx) && (IDX_W'(k) <= hit_idx_reg))
                    begin
                        val_reg[k] <= val_prev[k];
                        cnt_reg[k] <= cnt_prev[k];
                    end
                end
            end
        end
    end

    assign status       = status_reg;
    assign position     = pos_reg;
    assign access_count = acnt_reg;

endmodule

`default_nettype wire

>>> rtl/core/frequency_ordered_search_list_top.sv
// Flow: an input transfer is followed by a search over all cells in parallel and then an
//   update that shifts the cell chain and registers the result; a stalled output holds the
//   update. The next item is taken only in idle or in the update that retires the last one.
// Reset: rst_n is asynchronous, active low; it clears the controller, the output valid
//   and the fill count. Cell contents are undefined until appended.
`timescale 1ns / 1ps
`default_nettype none

module frequency_ordered_search_list_top import fosl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fosl_in_if.sink    in_ch,
    fosl_out_if.source out_ch
);

    dp_cmd_t cmd;

    // Controller: sequences idle, search and update, and owns both handshakes.
    // Input is taken in idle, or in the update cycle that retires the previous
    // item, so the next search already sees the updated table.
    fosl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // Datapath: the cell array with per-cell key compare, the count
    // comparators that pick the promotion slot, and the result register.
    fosl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (in_ch.opcode),
        .value        (in_ch.value),
        .status       (out_ch.status),
        .position     (out_ch.position),
        .access_count (out_ch.access_count)
    );

endmodule

`default_nettype wire

>>> rtl/core/fosl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "frequency_ordered_search_list_top_macros.svh"

module fosl_checker import fosl_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [STAT_W-1:0] status,
    input wire logic [POS_W-1:0]  position,
    input wire logic [ACNT_W-1:0] access_count
);

    logic in_xfer;
    logic acc_d1_reg, acc_d2_reg, acc_d3_reg;

    assign in_xfer = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_d1_reg <= 1'b0;
            acc_d2_reg <= 1'b0;
            acc_d3_reg <= 1'b0;
        end
        else
        begin
            acc_d1_reg <= in_xfer;
            acc_d2_reg <= acc_d1_reg;
            acc_d3_reg <= acc_d2_reg;
        end
    end

    `FOSL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `FOSL_ASSERT_NXT(a_in_spacing, in_xfer, !in_xfer, "input taken in back-to-back cycles")
    `FOSL_ASSERT_IMP(a_rise_latency, $rose(out_valid), acc_d3_reg, "result without matching input")
    `FOSL_ASSERT_IMP(a_fail_zero, out_valid && (status != ST_OK), (position == '0) && (access_count == '0), "failed result carries data")

endmodule

bind frequency_ordered_search_list_top fosl_checker u_fosl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .status       (out_ch.status),
    .position     (out_ch.position),
    .access_count (out_ch.access_count)
);

`default_nettype wire
